[src/wcsa_pkg.sv]
// shared codes and constants for the weighted cross stencil automaton
package wcsa_pkg;

  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 12;

  localparam int COLS_BITS  = 11;
  localparam int ROWS_BITS  = 11;
  localparam int BIAS_BITS  = 12;
  localparam int MASK_BITS  = 8;
  localparam int PIXEL_BITS = 8;
  localparam int SIZE_BITS  = 13;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_COLS = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_ROWS = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_BIAS = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MASK = 2'd3;

  localparam logic [COLS_BITS-1:0] COLS_RESET = 11'd320;
  localparam logic [ROWS_BITS-1:0] ROWS_RESET = 11'd200;
  localparam logic [BIAS_BITS-1:0] BIAS_RESET = 12'd0;
  localparam logic [MASK_BITS-1:0] MASK_RESET = 8'd255;

  localparam logic CMD_CELL  = 1'b0;
  localparam logic CMD_REMAP = 1'b1;

endpackage

[src/weighted_cross_stencil_automaton.sv]
// five point weighted stencil filter with line buffer memories and a display remap table
//
// usage
//   input channel (in_valid / in_stall): one transaction per source cell in raster
//   order, border ring included, (cols + 2) cells per row and (rows + 2) rows per
//   frame; start_of_frame marks the top left border cell. a transaction with
//   command set writes one remap table entry and gives no result.
//   output channel (out_valid / out_stall): one result per interior cell once its
//   south neighbor has arrived, with the remapped display pixel and a flag on the
//   last interior cell of the frame.
//   configuration (cfg_valid / cfg_ready): register writes are to be made only while idle;
//   the block itself does not enforce it, and cfg_ready is always high.
// timing
//   one transaction per cycle sustained while the output is not stalled. the line
//   buffers are read at the accepting edge, then the sum and the remap table read are
//   registered into the output register.
// reset and stall
//   counters, window and configuration reset; line buffers and remap table are not
//   cleared. a waiting result holds the next producing cell in the compute stage and
//   in_stall stays high until the output register drains.
module weighted_cross_stencil_automaton #(
  parameter int MAX_COLS  = 1024,
  parameter int MAX_ROWS  = 1024,
  parameter int CELL_BITS = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 command,
  input  logic                                 start_of_frame,
  input  logic [CELL_BITS-1:0]                 cell_value,
  input  logic [CELL_BITS-1:0]                 remap_index,
  input  logic [wcsa_pkg::PIXEL_BITS-1:0]      remap_value,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [CELL_BITS-1:0]                 new_cell,
  output logic [wcsa_pkg::PIXEL_BITS-1:0]      display_pixel,
  output logic                                 last_of_frame,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [wcsa_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [wcsa_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
  import wcsa_pkg::*;

  localparam int LINE_DEPTH  = MAX_COLS + 2;
  localparam int AW          = $clog2(LINE_DEPTH);
  localparam int RW          = $clog2(MAX_ROWS + 2);
  localparam int REMAP_DEPTH = 2 ** CELL_BITS;
  localparam int WB          = CELL_BITS + 3;
  localparam int SW          = ((WB + 1 > BIAS_BITS) ? WB + 1 : BIAS_BITS) + 1;

  typedef struct packed {
    logic                  is_cell;
    logic [AW-1:0]         addr;
    logic [CELL_BITS-1:0]  src_cell;
    logic                  produce;
    logic                  last;
    logic [CELL_BITS-1:0]  remap_index;
    logic [PIXEL_BITS-1:0] remap_value;
  } stage_t;

  logic [COLS_BITS-1:0]  cols_reg;
  logic [ROWS_BITS-1:0]  rows_reg;
  logic [BIAS_BITS-1:0]  bias_reg;
  logic [MASK_BITS-1:0]  mask_reg;

  logic [CELL_BITS-1:0]  l1_mem [LINE_DEPTH];
  logic [CELL_BITS-1:0]  l2_mem [LINE_DEPTH];
  logic [PIXEL_BITS-1:0] remap_mem [REMAP_DEPTH];

  logic [AW-1:0]         column_count;
  logic [RW-1:0]         row_count;
  logic [CELL_BITS-1:0]  prev_mid;

  stage_t                s1;
  logic                  s1_valid;
  logic [CELL_BITS-1:0]  l1_c_rd;
  logic [CELL_BITS-1:0]  l1_e_rd;
  logic [CELL_BITS-1:0]  l2_rd;
  logic                  fwd_a;
  logic                  fwd_e;
  logic [CELL_BITS-1:0]  fwd_cell;
  logic [CELL_BITS-1:0]  fwd_mid;

  logic [CELL_BITS-1:0]  new_cell_reg;
  logic                  last_reg;
  logic [PIXEL_BITS-1:0] remap_rd;

  logic                  accept;
  logic                  is_cell;
  logic                  s1_adv;
  logic                  line_wr;
  logic                  remap_wr;
  logic                  load_out;

  logic [SIZE_BITS-1:0]  cols_wide;
  logic [SIZE_BITS-1:0]  rows_wide;
  logic [AW-1:0]         cols_sat;
  logic [RW-1:0]         rows_sat;
  logic [AW-1:0]         c0;
  logic [RW-1:0]         r0;
  logic [AW:0]           c_ext;
  logic [AW:0]           cols_ext;
  logic [RW:0]           r_ext;
  logic [RW:0]           rows_ext;
  logic                  wrap_col;
  logic [AW-1:0]         column_count_next;
  logic [RW-1:0]         row_count_next;
  logic                  produce0;
  logic                  last0;
  logic [AW-1:0]         rd_a;
  logic [AW-1:0]         rd_e;

  logic [CELL_BITS-1:0]  mid_s1;
  logic [CELL_BITS-1:0]  north_s1;
  logic [CELL_BITS-1:0]  east_s1;
  logic [WB-1:0]         weighted;
  logic signed [SW-1:0]  sum;
  logic signed [SW-1:0]  shifted;
  logic [CELL_BITS-1:0]  t_val;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cols_reg <= COLS_RESET;
      rows_reg <= ROWS_RESET;
      bias_reg <= BIAS_RESET;
      mask_reg <= MASK_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_COLS: cols_reg <= cfg_data[COLS_BITS-1:0];
        CFG_ROWS: rows_reg <= cfg_data[ROWS_BITS-1:0];
        CFG_BIAS: bias_reg <= cfg_data[BIAS_BITS-1:0];
        CFG_MASK: mask_reg <= cfg_data[MASK_BITS-1:0];
        default: ;
      endcase
    end
  end

  // handshake
  assign s1_adv   = !(s1_valid && s1.is_cell && s1.produce && out_valid && out_stall);
  assign in_stall = !s1_adv;
  assign accept   = in_valid && !in_stall;
  assign is_cell  = (command == CMD_CELL);
  assign line_wr  = s1_valid && s1.is_cell && s1_adv;
  assign remap_wr = s1_valid && !s1.is_cell && s1_adv;
  assign load_out = s1_valid && s1.is_cell && s1.produce && s1_adv;

  // size saturation and raster position
  always_comb begin
    cols_wide = SIZE_BITS'(cols_reg);
    rows_wide = SIZE_BITS'(rows_reg);
    if (cols_wide == '0) begin
      cols_sat = AW'(1);
    end else if (cols_wide > SIZE_BITS'(MAX_COLS)) begin
      cols_sat = AW'(MAX_COLS);
    end else begin
      cols_sat = AW'(cols_wide);
    end
    if (rows_wide == '0) begin
      rows_sat = RW'(1);
    end else if (rows_wide > SIZE_BITS'(MAX_ROWS)) begin
      rows_sat = RW'(MAX_ROWS);
    end else begin
      rows_sat = RW'(rows_wide);
    end

    c0       = start_of_frame ? '0 : column_count;
    r0       = start_of_frame ? '0 : row_count;
    c_ext    = {1'b0, c0};
    r_ext    = {1'b0, r0};
    cols_ext = {1'b0, cols_sat};
    rows_ext = {1'b0, rows_sat};

    wrap_col = (c_ext >= cols_ext + (AW+1)'(1));
    if (wrap_col) begin
      column_count_next = '0;
      row_count_next    = (r_ext >= rows_ext + (RW+1)'(1)) ? '0 : r0 + RW'(1);
    end else begin
      column_count_next = c0 + AW'(1);
      row_count_next    = r0;
    end

    produce0 = (r_ext >= (RW+1)'(2)) && (c_ext >= (AW+1)'(1)) && (c_ext <= cols_ext);
    last0    = (r_ext == rows_ext + (RW+1)'(1)) && (c_ext == cols_ext);

    rd_a = c0;
    rd_e = (c0 == AW'(LINE_DEPTH - 1)) ? '0 : c0 + AW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept && is_cell) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

  // line buffers: write back from the compute stage, read for the arriving cell
  always_ff @(posedge clk) begin
    if (line_wr) begin
      l1_mem[s1.addr] <= s1.src_cell;
      l2_mem[s1.addr] <= mid_s1;
    end
    if (accept && is_cell) begin
      l1_c_rd <= l1_mem[rd_a];
      l1_e_rd <= l1_mem[rd_e];
      l2_rd   <= l2_mem[rd_a];
    end
  end

  // forwarding of the write that lands on the same edge as the read
  always_ff @(posedge clk) begin
    if (accept && is_cell) begin
      fwd_a    <= line_wr && (s1.addr == rd_a);
      fwd_e    <= line_wr && (s1.addr == rd_e);
      fwd_cell <= s1.src_cell;
      fwd_mid  <= mid_s1;
    end
  end

  // compute stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_adv) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1.is_cell     <= is_cell;
      s1.addr        <= c0;
      s1.src_cell    <= cell_value;
      s1.produce     <= produce0;
      s1.last        <= last0;
      s1.remap_index <= remap_index;
      s1.remap_value <= remap_value;
    end
  end

  // west cell of the window
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_mid <= '0;
    end else if (line_wr) begin
      prev_mid <= mid_s1;
    end
  end

  // weighted sum
  always_comb begin
    mid_s1   = fwd_a ? fwd_cell : l1_c_rd;
    north_s1 = fwd_a ? fwd_mid : l2_rd;
    east_s1  = fwd_e ? fwd_cell : l1_e_rd;
    weighted = WB'(north_s1) + WB'(s1.src_cell)
             + ((WB'(prev_mid) + WB'(mid_s1) + WB'(east_s1)) << 1);
    sum      = $signed({{(SW-WB){1'b0}}, weighted})
             + $signed({{(SW-BIAS_BITS){bias_reg[BIAS_BITS-1]}}, bias_reg});
    shifted  = sum >>> 3;
    t_val    = sum[SW-1] ? '0 : (shifted[CELL_BITS-1:0] & CELL_BITS'(mask_reg));
  end

  // remap table
  always_ff @(posedge clk) begin
    if (remap_wr) begin
      remap_mem[s1.remap_index] <= s1.remap_value;
    end
    if (load_out) begin
      remap_rd <= remap_mem[t_val];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      new_cell_reg <= t_val;
      last_reg     <= s1.last;
    end
  end

  assign new_cell      = new_cell_reg;
  assign last_of_frame = last_reg;
  assign display_pixel = remap_rd;

endmodule

[tb/weighted_cross_stencil_automaton_checker.sv]
`timescale 1ns / 100ps
// result checker for the stencil automaton: predicts each result and compares it with the block
module weighted_cross_stencil_automaton_checker
  import wcsa_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic                      command,
  input  logic                      start_of_frame,
  input  logic [7:0]                cell_value,
  input  logic [7:0]                remap_index,
  input  logic [PIXEL_BITS-1:0]     remap_value,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic [7:0]                new_cell,
  input  logic [PIXEL_BITS-1:0]     display_pixel,
  input  logic                      last_of_frame,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  output int                        pending_results,
  output int                        fail_count
);

  localparam int MAX_COLS   = 1024;
  localparam int MAX_ROWS   = 1024;
  localparam int LINE_CELLS = MAX_COLS + 2;

  typedef struct packed {
    logic [7:0]            new_val;
    logic [PIXEL_BITS-1:0] pixel;
    logic                  frame_end;
  } stencil_result_t;

  logic [7:0]            above_row     [LINE_CELLS];
  logic [7:0]            two_above_row [LINE_CELLS];
  logic [PIXEL_BITS-1:0] remap_copy    [256];
  logic [23:0]           window_cells;
  int                    col_pos;
  int                    row_pos;
  logic [COLS_BITS-1:0]  cols_reg;
  logic [ROWS_BITS-1:0]  rows_reg;
  logic [BIAS_BITS-1:0]  bias_reg;
  logic [MASK_BITS-1:0]  mask_reg;
  stencil_result_t       expected_q [$];
  int                    mismatches = 0;

  function automatic int clip_size(input int v, input int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic filter_cell(input logic [7:0] src);
    int cols, rows, c, r, north, mid, west, centre, east, sum, scaled;
    stencil_result_t res;
    cols = clip_size(cols_reg, MAX_COLS);
    rows = clip_size(rows_reg, MAX_ROWS);
    if (start_of_frame) begin
      col_pos = 0;
      row_pos = 0;
    end
    c = col_pos;
    r = row_pos;
    north = two_above_row[c];
    mid = above_row[c];
    window_cells = {window_cells[15:0], 8'(mid)};
    if (r >= 2 && c >= 1 && c <= cols) begin
      west = window_cells[15:8];
      centre = window_cells[7:0];
      east = above_row[c + 1];
      sum = north + int'(src) + 2 * (west + centre + east) + int'($signed(bias_reg));
      scaled = (sum < 0) ? 0 : (sum >>> 3);
      res.new_val = 8'(scaled) & mask_reg;
      res.pixel = remap_copy[res.new_val];
      res.frame_end = (r == rows + 1 && c == cols);
      expected_q.push_back(res);
    end
    if (c < LINE_CELLS) begin
      two_above_row[c] = 8'(mid);
      above_row[c] = src;
    end
    if (c >= cols + 1) begin
      col_pos = 0;
      row_pos = (r >= rows + 1) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endtask

  task automatic check_result();
    stencil_result_t want;
    if (expected_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result: new_cell %0d display_pixel %0d last_of_frame %0d",
                 new_cell, display_pixel, last_of_frame);
      return;
    end
    want = expected_q.pop_front();
    if (new_cell !== want.new_val || display_pixel !== want.pixel ||
        last_of_frame !== want.frame_end) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: new_cell %0d/%0d display_pixel %0d/%0d last_of_frame %0d/%0d",
                 want.new_val, new_cell, want.pixel, display_pixel,
                 want.frame_end, last_of_frame);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cols_reg = COLS_RESET;
      rows_reg = ROWS_RESET;
      bias_reg = BIAS_RESET;
      mask_reg = MASK_RESET;
      window_cells = '0;
      col_pos = 0;
      row_pos = 0;
      expected_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_COLS: cols_reg = cfg_data[COLS_BITS-1:0];
          CFG_ROWS: rows_reg = cfg_data[ROWS_BITS-1:0];
          CFG_BIAS: bias_reg = cfg_data[BIAS_BITS-1:0];
          CFG_MASK: mask_reg = cfg_data[MASK_BITS-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (command == CMD_REMAP) remap_copy[remap_index] = remap_value;
        else filter_cell(cell_value);
      end
      if (out_valid && !out_stall) check_result();
    end
    pending_results <= expected_q.size();
    fail_count <= mismatches;
  end

endmodule

[tb/weighted_cross_stencil_automaton_tb.sv]
`timescale 1ns / 100ps
// testbench top for the stencil automaton: drives frames, remap loads and settings, gives verdict
module weighted_cross_stencil_automaton_tb;
  import wcsa_pkg::*;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic                      command = CMD_CELL;
  logic                      start_of_frame = 1'b0;
  logic [7:0]                cell_value = '0;
  logic [7:0]                remap_index = '0;
  logic [PIXEL_BITS-1:0]     remap_value = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [7:0]                new_cell;
  logic [PIXEL_BITS-1:0]     display_pixel;
  logic                      last_of_frame;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
  int                        pending_results;
  int                        fail_count;

  int burst_left = 0;
  int items_sent = 0;
  int cur_cols = 320;
  int cur_rows = 200;
  int stall_mode = 0;
  int stall_run = 0;

  always #5 clk = ~clk;

  weighted_cross_stencil_automaton u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .command        (command),
    .start_of_frame (start_of_frame),
    .cell_value     (cell_value),
    .remap_index    (remap_index),
    .remap_value    (remap_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .new_cell       (new_cell),
    .display_pixel  (display_pixel),
    .last_of_frame  (last_of_frame),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  weighted_cross_stencil_automaton_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .command         (command),
    .start_of_frame  (start_of_frame),
    .cell_value      (cell_value),
    .remap_index     (remap_index),
    .remap_value     (remap_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .new_cell        (new_cell),
    .display_pixel   (display_pixel),
    .last_of_frame   (last_of_frame),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .pending_results (pending_results),
    .fail_count      (fail_count)
  );

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_run == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_run = $urandom_range(8, 120);
      end
      stall_run--;
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 1) == 0);
        default: out_stall <= ($urandom_range(0, 9) < 8);
      endcase
    end
  end

  task automatic push_item(input logic cmd, input logic sof, input logic [7:0] src,
                           input logic [7:0] ridx, input logic [PIXEL_BITS-1:0] rval);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    command <= cmd;
    start_of_frame <= sof;
    cell_value <= src;
    remap_index <= ridx;
    remap_value <= rval;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic load_remap(input logic [7:0] ridx, input logic [PIXEL_BITS-1:0] rval);
    push_item(CMD_REMAP, $urandom_range(0, 7) == 0, 8'($urandom), ridx, rval);
  endtask

  function automatic logic [7:0] pick_cell(input int style);
    case (style)
      1: return 8'h00;
      2: return 8'hFF;
      3: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      4: return 8'($urandom_range(0, 7));
      default: return 8'($urandom);
    endcase
  endfunction

  // raster frame with border ring; cut stops early, resync_at raises start_of_frame mid-frame
  task automatic send_frame(input int ncols, input int nrows, input bit use_sof,
                            input int cut, input int resync_at, input int style);
    int total;
    logic sof;
    total = (ncols + 2) * (nrows + 2);
    if (cut > 0) total = cut;
    for (int k = 0; k < total; k++) begin
      sof = (k == 0 && use_sof) || (k == resync_at);
      if ($urandom_range(0, 15) == 0) load_remap(8'($urandom), 8'($urandom));
      push_item(CMD_CELL, sof, pick_cell(style), 8'($urandom), 8'($urandom));
    end
  endtask

  task automatic quiesce();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  function automatic int fit_size(input int v);
    if (v < 1) return 1;
    if (v > 1024) return 1024;
    return v;
  endfunction

  task automatic apply_settings(input logic [11:0] cols_raw, input logic [11:0] rows_raw,
                                input logic [11:0] bias_raw, input logic [11:0] mask_raw);
    quiesce();
    write_reg(CFG_COLS, cols_raw);
    write_reg(CFG_ROWS, rows_raw);
    write_reg(CFG_BIAS, bias_raw);
    write_reg(CFG_MASK, mask_raw);
    cfg_valid <= 1'b0;
    cur_cols = fit_size(cols_raw[COLS_BITS-1:0]);
    cur_rows = fit_size(rows_raw[ROWS_BITS-1:0]);
  endtask

  initial begin
    int base, nframes, kind, total;
    logic [11:0] cols_raw, rows_raw, bias_raw, mask_raw;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < 256; i++) load_remap(8'(i), 8'($urandom));

    // both sizes given out of range, frames cut short
    apply_settings(12'hFFF, 12'h000, 12'h000, 12'h0FF);
    send_frame(cur_cols, cur_rows, 1, 40, -1, 0);
    apply_settings(12'h000, 12'h7FF, 12'h800, 12'h00F);
    send_frame(cur_cols, cur_rows, 1, 60, -1, 0);

    // widest frame of the random mix
    apply_settings(12'd24, 12'd1, 12'h000, 12'h0FF);
    send_frame(cur_cols, cur_rows, 1, 0, -1, 0);

    // bias and cell value extremes, then a frame that wraps without a frame marker
    apply_settings(12'd3, 12'd2, 12'h7FF, 12'h0FF);
    send_frame(cur_cols, cur_rows, 1, 0, -1, 2);
    apply_settings(12'd3, 12'd2, 12'h800, 12'h0FF);
    send_frame(cur_cols, cur_rows, 1, 0, -1, 3);
    send_frame(cur_cols, cur_rows, 0, 0, -1, 1);

    // width lowered while the counters sit mid-frame
    apply_settings(12'd6, 12'd3, 12'h000, 12'h0FF);
    send_frame(cur_cols, cur_rows, 1, 22, -1, 0);
    apply_settings(12'd2, 12'd3, 12'h004, 12'h0AA);
    send_frame(cur_cols, cur_rows, 0, 0, -1, 0);
    send_frame(cur_cols, cur_rows, 1, 0, -1, 0);

    base = items_sent;
    while (items_sent - base < 220) begin
      case ($urandom_range(0, 9))
        0: cols_raw = 12'h000;
        1: cols_raw = 12'($urandom_range(9, 24));
        default: cols_raw = 12'($urandom_range(1, 8));
      endcase
      rows_raw = ($urandom_range(0, 9) == 0) ? 12'h000 : 12'($urandom_range(1, 5));
      bias_raw = $urandom_range(0, 1) ? 12'($urandom) : 12'($urandom_range(0, 15) - 8);
      mask_raw = $urandom_range(0, 1) ? 12'h0FF : 12'($urandom_range(0, 255));
      apply_settings(cols_raw, rows_raw, bias_raw, mask_raw);
      nframes = $urandom_range(1, 4);
      for (int f = 0; f < nframes; f++) begin
        kind = $urandom_range(0, 9);
        total = (cur_cols + 2) * (cur_rows + 2);
        case (kind)
          0: send_frame(cur_cols, cur_rows, 0, 0, -1, $urandom_range(0, 6));
          1: send_frame(cur_cols, cur_rows, 1, $urandom_range(1, total - 1), -1,
                        $urandom_range(0, 6));
          2: send_frame(cur_cols, cur_rows, 1, 0, $urandom_range(1, total - 1),
                        $urandom_range(0, 6));
          default: send_frame(cur_cols, cur_rows, 1, 0, -1, $urandom_range(0, 6));
        endcase
      end
    end

    quiesce();
    repeat (8) @(posedge clk);
    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
